// ===== hw/rtl/pls_pkg.sv =====
// Shared types and constants for the positional list store.
package pls_pkg;

  localparam int DATA_W           = 32;
  localparam int POS_W            = 8;
  localparam int LEN_OUT_W        = 8;
  localparam int OP_W             = 3;
  localparam int DEFAULT_CAPACITY = 128;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_UPDATE = 3'd1,
    OP_DELETE = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_POS  = 2'd2
  } status_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic step;
    logic commit;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_shift;
    logic at_end;
  } dp_stat_t;

endpackage

// ===== hw/rtl/pls_datapath.sv =====
// Datapath: entry memory, length register, shift pointer and result registers.
module pls_datapath #(
  parameter int CAPACITY = pls_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pls_pkg::ctl_cmd_t                   cmd,
  output pls_pkg::dp_stat_t                   stat,
  input  logic [pls_pkg::OP_W-1:0]            operation,
  input  logic [pls_pkg::POS_W-1:0]           position,
  input  logic signed [pls_pkg::DATA_W-1:0]   value,
  output logic [1:0]                          status,
  output logic signed [pls_pkg::DATA_W-1:0]   read_value,
  output logic [pls_pkg::LEN_OUT_W-1:0]       list_length
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > pls_pkg::POS_W) ? LW : pls_pkg::POS_W;

  logic [pls_pkg::DATA_W-1:0] mem [CAPACITY];
  logic [pls_pkg::DATA_W-1:0] rd_data;

  logic [pls_pkg::OP_W-1:0]   cmd_op;
  logic [pls_pkg::POS_W-1:0]  cmd_pos;
  logic [pls_pkg::DATA_W-1:0] cmd_val;
  pls_pkg::status_t           status_r;
  pls_pkg::status_t           status_now;
  logic [LW-1:0]              list_len;
  logic [AW-1:0]              ptr;
  logic [AW-1:0]              wr_addr;
  logic                       wr_pend;

  logic [CW-1:0]              pos_c;
  logic [CW-1:0]              len_c;
  logic [AW-1:0]              pos_a;
  logic                       is_ins;
  logic                       is_del;
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [pls_pkg::DATA_W-1:0] wdata;
  logic [AW-1:0]              raddr;

  assign pos_c  = CW'(cmd_pos);
  assign len_c  = CW'(list_len);
  assign pos_a  = AW'(pos_c);
  assign is_ins = (cmd_op == pls_pkg::OP_INSERT);
  assign is_del = (cmd_op == pls_pkg::OP_DELETE);

  always_comb begin
    status_now = pls_pkg::ST_OK;
    case (cmd_op)
      pls_pkg::OP_INSERT: begin
        if (len_c >= CW'(CAPACITY)) begin
          status_now = pls_pkg::ST_FULL;
        end else if (pos_c > len_c) begin
          status_now = pls_pkg::ST_POS;
        end
      end
      pls_pkg::OP_UPDATE, pls_pkg::OP_DELETE, pls_pkg::OP_READ: begin
        if (pos_c >= len_c) begin
          status_now = pls_pkg::ST_POS;
        end
      end
      default: status_now = pls_pkg::ST_OK;
    endcase
  end

  assign stat.need_shift = (is_ins || is_del) && (status_now == pls_pkg::ST_OK);
  assign stat.at_end     = is_ins ? (ptr == pos_a)
                                  : ((CW'(ptr) + CW'(1)) >= len_c);

  always_comb begin
    we    = 1'b0;
    waddr = pos_a;
    wdata = cmd_val;
    if (wr_pend) begin
      we    = 1'b1;
      waddr = wr_addr;
      wdata = rd_data;
    end else if (cmd.commit && (status_r == pls_pkg::ST_OK) &&
                 (is_ins || (cmd_op == pls_pkg::OP_UPDATE))) begin
      we = 1'b1;
    end
  end

  always_comb begin
    raddr = pos_a;
    if (cmd.step) begin
      raddr = is_ins ? (ptr - AW'(1)) : (ptr + AW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_op  <= operation;
      cmd_pos <= position;
      cmd_val <= value;
    end
    if (cmd.decode) begin
      status_r <= status_now;
      ptr      <= is_ins ? AW'(list_len) : pos_a;
    end else if (cmd.step) begin
      ptr <= is_ins ? (ptr - AW'(1)) : (ptr + AW'(1));
    end
    if (cmd.step) begin
      wr_addr <= ptr;
    end
    if (cmd.load_out) begin
      status      <= status_r;
      read_value  <= ((cmd_op == pls_pkg::OP_READ) && (status_r == pls_pkg::ST_OK))
                     ? rd_data : '0;
      list_length <= pls_pkg::LEN_OUT_W'(list_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_len <= '0;
      wr_pend  <= 1'b0;
    end else begin
      wr_pend <= cmd.step;
      if (cmd.commit && (status_r == pls_pkg::ST_OK)) begin
        case (cmd_op)
          pls_pkg::OP_INSERT: list_len <= list_len + LW'(1);
          pls_pkg::OP_DELETE: list_len <= list_len - LW'(1);
          pls_pkg::OP_CLEAR:  list_len <= '0;
          default:            list_len <= list_len;
        endcase
      end
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(list_len) <= CW'(CAPACITY))
    else $error("list length above capacity");

  a_step_writes: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> wr_pend)
    else $error("shift step without a following write");

  a_commit_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !wr_pend)
    else $error("commit while a shift write is pending");

endmodule

// ===== hw/rtl/pls_ctrl.sv =====
// Controller: sequences decode, shift, commit and result handoff.
module pls_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pls_pkg::dp_stat_t stat,
  output pls_pkg::ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_FINISH,
    S_RESP
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  assign cmd.capture  = (state == S_IDLE) && in_valid && in_ready;
  assign cmd.decode   = (state == S_DECODE);
  assign cmd.step     = (state == S_SHIFT) && !stat.at_end;
  assign cmd.commit   = (state == S_FINISH);
  assign cmd.load_out = (state == S_RESP) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !cmd.load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            in_ready <= 1'b0;
            state    <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= stat.need_shift ? S_SHIFT : S_FINISH;
        end
        S_SHIFT: begin
          if (stat.at_end) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            in_ready  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == S_IDLE))
    else $error("ready outside idle");

  a_capture_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_DECODE))
    else $error("accepted transaction not decoded");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result loaded without valid");

endmodule

// ===== hw/rtl/positional_list_store.sv =====
// Top level of the positional list store.
// Ordered list of signed 32-bit entries, up to CAPACITY, with positional edits.
// Input channel (in_valid/in_ready) carries operation, position and value;
// output channel (out_valid/out_ready) returns status, read_value and
// list_length for every transaction, one result per command.
// One command is in flight at a time. A command that moves no entries passes
// through the decode, finish and response states; a successful insert or
// delete also passes through the shift state (insert at position p into a
// list of n entries moves n-p, delete moves n-p-1). The next command can be
// accepted in the same cycle that its result turns valid. The shift is a
// two-port memory copy of one entry per cycle: each entry is read, then
// written in the following cycle, overlapped with the next read.
// Reset empties the list (length zero); entry contents are not cleared and
// need no clearing pass. A result waits in the output register while the
// receiver stalls; the next command is accepted only once that register
// takes the result.
module positional_list_store #(
  parameter int CAPACITY = pls_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pls_pkg::OP_W-1:0]            operation,
  input  logic [pls_pkg::POS_W-1:0]           position,
  input  logic signed [pls_pkg::DATA_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          status,
  output logic signed [pls_pkg::DATA_W-1:0]   read_value,
  output logic [pls_pkg::LEN_OUT_W-1:0]       list_length
);

  pls_pkg::ctl_cmd_t cmd;
  pls_pkg::dp_stat_t stat;

  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pls_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (operation),
    .position    (position),
    .value       (value),
    .status      (status),
    .read_value  (read_value),
    .list_length (list_length)
  );

endmodule

// ===== verif/list_store_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the positional list store: shadow list, expected replies and checks.
package list_store_tb_pkg;
  import pls_pkg::*;

  typedef struct {
    logic [1:0]               st;
    logic signed [DATA_W-1:0] rd;
    logic [LEN_OUT_W-1:0]     len;
  } list_reply_t;

  class list_shadow;
    int                       capacity;
    int                       length;
    logic signed [DATA_W-1:0] entries[];
    list_reply_t              due_replies[$];
    int                       mismatches;

    function new(int cap);
      capacity = cap;
      length = 0;
      mismatches = 0;
      entries = new[cap];
      foreach (entries[k]) entries[k] = '0;
    endfunction

    function int pending();
      return due_replies.size();
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      list_reply_t r;
      int          p;
      int          k;
      p = int'(pos);
      r.st = ST_OK;
      r.rd = '0;
      case (op)
        OP_INSERT: begin
          if (length >= capacity) begin
            r.st = ST_FULL;
          end else if (p > length) begin
            r.st = ST_POS;
          end else begin
            for (k = length; k > p; k--) entries[k] = entries[k-1];
            entries[p] = val;
            length++;
          end
        end
        OP_UPDATE: begin
          if (p >= length) r.st = ST_POS;
          else entries[p] = val;
        end
        OP_DELETE: begin
          if (p >= length) begin
            r.st = ST_POS;
          end else begin
            for (k = p; k + 1 < length; k++) entries[k] = entries[k+1];
            length--;
          end
        end
        OP_READ: begin
          if (p >= length) r.st = ST_POS;
          else r.rd = entries[p];
        end
        OP_CLEAR: length = 0;
        default: ;
      endcase
      r.len = length[LEN_OUT_W-1:0];
      due_replies.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic signed [DATA_W-1:0] rd,
                               logic [LEN_OUT_W-1:0] len);
      list_reply_t want;
      if (due_replies.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected reply: status %0d read_value %0d length %0d", st, rd, len);
        mismatches++;
        return;
      end
      want = due_replies.pop_front();
      if (want.st !== st || want.rd !== rd || want.len !== len) begin
        if (mismatches < 10)
          $display("mismatch: status %0d/%0d read_value %0d/%0d length %0d/%0d (exp/act)",
                   want.st, st, want.rd, rd, want.len, len);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top-level testbench for the positional list store.
module testbench;
  import pls_pkg::*;
  import list_store_tb_pkg::*;

  localparam int CAPACITY     = DEFAULT_CAPACITY;
  localparam int OP_CODES     = 8;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = CAPACITY + 16;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          operation = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] read_value;
  logic [LEN_OUT_W-1:0]     list_length;

  list_shadow book;
  int         send_idle = 0;
  int         recv_idle = 0;
  int         quiet_cycles = 0;

  positional_list_store #(.CAPACITY(CAPACITY)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .read_value  (read_value),
    .list_length (list_length)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) book.check_result(status, read_value, list_length);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_command(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_command(op, pos, val);
  endtask

  // hold the sender until every pending reply is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_command();
    int              r;
    int              len;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    len = book.length;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_command(OP_W'($urandom_range(0, OP_CODES - 1)), POS_W'($urandom_range(0, 255)),
                   $urandom);
      return;
    end
    if (r < 40) op = OP_INSERT;
    else if (r < 55) op = OP_UPDATE;
    else if (r < 75) op = OP_DELETE;
    else if (r < 97) op = OP_READ;
    else op = OP_CLEAR;
    if ($urandom_range(0, 99) < 15 || (len == 0 && op != OP_INSERT)) begin
      case ($urandom_range(0, 3))
        0:       pos = POS_W'(len);
        1:       pos = POS_W'(len + 1);
        2:       pos = POS_W'(CAPACITY);
        default: pos = POS_W'($urandom_range(0, 255));
      endcase
    end else if (op == OP_INSERT) begin
      pos = POS_W'($urandom_range(0, len));
    end else begin
      pos = POS_W'($urandom_range(0, len - 1));
    end
    send_command(op, pos, pick_value());
  endtask

  initial begin
    book = new(CAPACITY);
    send_idle = 19;
    recv_idle = 69;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_command(OP_READ, POS_W'(0), 0);
    send_command(OP_DELETE, POS_W'(0), 0);
    send_command(OP_UPDATE, POS_W'(0), 1);
    send_command(OP_INSERT, POS_W'(1), 2);
    send_command(OP_INSERT, POS_W'(0), 32'sh7FFF_FFFF);
    send_command(OP_INSERT, POS_W'(1), 32'sh8000_0000);
    send_command(OP_INSERT, POS_W'(0), -1);
    send_command(OP_INSERT, POS_W'(1), 0);
    send_command(OP_INSERT, 8'hFF, 3);
    for (int p = 0; p <= 4; p++) send_command(OP_READ, POS_W'(p), 0);
    send_command(OP_UPDATE, POS_W'(3), 32'sh5555_5555);
    send_command(OP_UPDATE, POS_W'(4), 7);
    send_command(OP_DELETE, POS_W'(1), 0);
    send_command(OP_DELETE, POS_W'(2), 0);
    send_command(OP_DELETE, POS_W'(0), 0);
    send_command(OP_READ, POS_W'(0), 0);
    for (int c = int'(OP_CLEAR) + 1; c < OP_CODES; c++)
      send_command(OP_W'(c), POS_W'($urandom_range(0, 255)), $urandom);
    send_command(OP_CLEAR, POS_W'($urandom_range(0, 255)), $urandom);
    send_command(OP_READ, POS_W'(0), 0);

    // grow the list to capacity, then hit it while full
    while (book.length < CAPACITY)
      send_command(OP_INSERT, POS_W'($urandom_range(0, book.length)), pick_value());
    repeat (3) send_command(OP_INSERT, POS_W'($urandom_range(0, 255)), pick_value());
    wait_drained();
    repeat (10) random_command();
    wait_drained();

    send_idle = 69;
    recv_idle = 19;
    repeat (130) random_command();
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    repeat (130) random_command();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
